// File: rtl/isms_pkg.sv
// package for the interval set merge/split unit
// holds default sizes, port field widths and command/status codes
// no dependencies
package isms_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int VALUE_BITS_DEF = 32;

   // fixed widths of the port fields
   localparam int FIELD_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 5;

   // command codes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_ARGS = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

endpackage

// File: rtl/isms_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module isms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/interval_set_merge_split_unit.sv
// top level of the interval set merge/split unit
// depends on isms_pkg and isms_ram
//
// Keeps a sorted table of disjoint closed intervals. The req_ channel takes
// a command (add or remove) with bounds lo and hi; the rsp_ channel returns
// one result per command: status, entry count and the lowest and highest
// value of the set (both 0 when the set is empty).
// The table lives in one ram holding two banks. A command streams the
// current bank, one entry per cycle while no split or insertion holds the
// stream, through a merge/cut stage and writes the new table into the
// other bank; the banks swap only on success, so a full table is left
// untouched. A split or an insertion in front of an entry holds the read
// stream while the extra piece is written. At most DEPTH entries are
// stored. Reversed bounds skip the table pass. One command is worked on
// at a time; the next one is taken in the cycle after the previous one
// has moved into the result register. Reset empties the set at once, no
// clearing pass. A stalled receiver holds the result in the output
// register; a following command is still taken and worked through, then
// waits until the result is taken.
module interval_set_merge_split_unit #(
   parameter int DEPTH      = isms_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = isms_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic signed [isms_pkg::FIELD_BITS-1:0] req_lo,
   input  logic signed [isms_pkg::FIELD_BITS-1:0] req_hi,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [isms_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [isms_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   output logic signed [isms_pkg::FIELD_BITS-1:0] rsp_set_low,
   output logic signed [isms_pkg::FIELD_BITS-1:0] rsp_set_high
);

   import isms_pkg::*;

   localparam int VB   = VALUE_BITS;
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int WCW  = $clog2(DEPTH + 2);
   localparam int RAMD = 2 << AW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  cmd_ff, bad_ff;
   logic signed [VB-1:0]  lo_ff, hi_ff;
   logic signed [VB-1:0]  nl_ff, nl_in, nu_ff, nu_in;
   logic                  placed_ff, placed_in, second_ff, second_in;
   logic [CW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic                  d_vld_ff, d_vld_in;
   logic [WCW-1:0]        wr_cnt_ff, wr_cnt_in;
   logic signed [VB-1:0]  first_l_ff, first_l_in, last_u_ff, last_u_in;
   logic [CW-1:0]         count_ff;
   logic                  bank_ff;
   logic signed [VB-1:0]  low_ff, high_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [CW-1:0]         rsp_count_ff;
   logic signed [VB-1:0]  rsp_low_ff, rsp_high_ff;

   logic                  re, we, emit, consume, finish, fail;
   logic signed [VB-1:0]  w_l, w_u, e_l, e_u;
   logic [2*VB-1:0]       rd_data;
   logic signed [VB:0]    e_l_x, e_u_x, lo_x, hi_x;
   logic                  has_l, has_r, overlap;
   logic signed [VB-1:0]  in_lo, in_hi;

   assign in_lo = VB'(req_lo);
   assign in_hi = VB'(req_hi);

   // table storage, two banks selected by the top address bit
   isms_ram #(
      .WIDTH(2 * VB),
      .DEPTH(RAMD)
   ) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr({~bank_ff, wr_cnt_ff[AW-1:0]}),
      .wr_data({w_l, w_u}),
      .rd_en  (re),
      .rd_addr({bank_ff, rd_ptr_ff[AW-1:0]}),
      .rd_data(rd_data)
   );

   assign e_l   = rd_data[2*VB-1:VB];
   assign e_u   = rd_data[VB-1:0];
   assign e_l_x = (VB+1)'(e_l);
   assign e_u_x = (VB+1)'(e_u);
   assign lo_x  = (VB+1)'(lo_ff);
   assign hi_x  = (VB+1)'(hi_ff);

   // cut pieces for remove
   assign overlap = !(e_u < lo_ff) && !(e_l > hi_ff);
   assign has_l   = e_l < lo_ff;
   assign has_r   = e_u > hi_ff;

   // streaming merge/cut step
   always_comb begin
      nl_in     = nl_ff;
      nu_in     = nu_ff;
      placed_in = placed_ff;
      second_in = second_ff;
      emit      = 1'b0;
      w_l       = e_l;
      w_u       = e_u;
      consume   = 1'b0;
      finish    = 1'b0;
      if (d_vld_ff) begin
         if (cmd_ff == CMD_ADD) begin
            priority if (placed_ff) begin
               emit    = 1'b1;
               consume = 1'b1;
            end else if (e_u_x + 1 < lo_x) begin
               emit    = 1'b1;
               consume = 1'b1;
            end else if (hi_x + 1 < e_l_x) begin
               // new interval goes in front of this entry
               emit      = 1'b1;
               w_l       = nl_ff;
               w_u       = nu_ff;
               placed_in = 1'b1;
            end else begin
               if (e_l < nl_ff) nl_in = e_l;
               if (e_u > nu_ff) nu_in = e_u;
               consume = 1'b1;
            end
         end else begin
            priority if (!overlap) begin
               emit    = 1'b1;
               consume = 1'b1;
            end else if (second_ff) begin
               emit      = 1'b1;
               w_l       = hi_ff + 1'b1;
               second_in = 1'b0;
               consume   = 1'b1;
            end else if (has_l && has_r) begin
               // split: left piece now, right piece next cycle
               emit      = 1'b1;
               w_u       = lo_ff - 1'b1;
               second_in = 1'b1;
            end else if (has_l) begin
               emit    = 1'b1;
               w_u     = lo_ff - 1'b1;
               consume = 1'b1;
            end else if (has_r) begin
               emit    = 1'b1;
               w_l     = hi_ff + 1'b1;
               consume = 1'b1;
            end else begin
               consume = 1'b1;
            end
         end
      end else if (rd_ptr_ff == count_ff) begin
         finish = 1'b1;
         if (cmd_ff == CMD_ADD && !placed_ff) begin
            emit = 1'b1;
            w_l  = nl_ff;
            w_u  = nu_ff;
         end
      end else begin
         consume = 1'b1;
      end
      if (state_ff != ST_RUN) begin
         emit    = 1'b0;
         consume = 1'b0;
         finish  = 1'b0;
      end
   end

   // read pointer and write side
   always_comb begin
      re         = consume && (rd_ptr_ff != count_ff);
      rd_ptr_in  = rd_ptr_ff + CW'(re);
      d_vld_in   = consume ? re : d_vld_ff;
      we         = emit && (wr_cnt_ff < WCW'(DEPTH));
      wr_cnt_in  = wr_cnt_ff + WCW'(emit);
      first_l_in = (emit && wr_cnt_ff == '0) ? w_l : first_l_ff;
      last_u_in  = emit ? w_u : last_u_ff;
      fail       = wr_cnt_ff > WCW'(DEPTH);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = (in_lo > in_hi) ? ST_DONE : ST_RUN;
         ST_RUN:  if (finish) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         d_vld_ff     <= 1'b0;
         placed_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               d_vld_ff  <= 1'b0;
               placed_ff <= 1'b0;
               second_ff <= 1'b0;
               rd_ptr_ff <= '0;
               wr_cnt_ff <= '0;
            end
            ST_RUN: begin
               d_vld_ff  <= d_vld_in;
               placed_ff <= placed_in;
               second_ff <= second_in;
               rd_ptr_ff <= rd_ptr_in;
               wr_cnt_ff <= wr_cnt_in;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  if (!bad_ff && !fail) begin
                     count_ff <= CW'(wr_cnt_ff);
                     bank_ff  <= ~bank_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff <= req_cmd;
         lo_ff  <= in_lo;
         hi_ff  <= in_hi;
         nl_ff  <= in_lo;
         nu_ff  <= in_hi;
         bad_ff <= in_lo > in_hi;
      end else if (state_ff == ST_RUN) begin
         nl_ff <= nl_in;
         nu_ff <= nu_in;
      end
      if (state_ff == ST_RUN) begin
         first_l_ff <= first_l_in;
         last_u_ff  <= last_u_in;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         if (bad_ff) begin
            rsp_status_ff <= STATUS_BAD_ARGS;
            rsp_count_ff  <= count_ff;
            rsp_low_ff    <= low_ff;
            rsp_high_ff   <= high_ff;
         end else if (fail) begin
            rsp_status_ff <= STATUS_FULL;
            rsp_count_ff  <= count_ff;
            rsp_low_ff    <= low_ff;
            rsp_high_ff   <= high_ff;
         end else begin
            rsp_status_ff <= STATUS_OK;
            rsp_count_ff  <= CW'(wr_cnt_ff);
            rsp_low_ff    <= (wr_cnt_ff == '0) ? '0 : first_l_ff;
            rsp_high_ff   <= (wr_cnt_ff == '0) ? '0 : last_u_ff;
         end
      end
      // bounds of the committed set
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready) && !bad_ff && !fail) begin
         low_ff  <= (wr_cnt_ff == '0) ? '0 : first_l_ff;
         high_ff <= (wr_cnt_ff == '0) ? '0 : last_u_ff;
      end
   end

   // result port
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = COUNT_BITS'(rsp_count_ff);
   assign rsp_set_low     = FIELD_BITS'(rsp_low_ff);
   assign rsp_set_high    = FIELD_BITS'(rsp_high_ff);

endmodule
